@@ rtl/srts_pkg.sv @@
// Shared types, constants and helpers for the signed radix to symbols block.
// No dependencies; imported by every module of the block.
`default_nettype none

package srts_pkg;

  localparam int unsigned MaxRadix  = 16;
  localparam int unsigned SymSlots  = 16;
  localparam int unsigned MaxDigits = 32;
  localparam int unsigned QDepth    = 2;

  localparam logic [7:0] MinusSym = 8'h2D;
  localparam logic [7:0] PlusSym  = 8'h2B;

  typedef enum logic [1:0] {
    CFG_RADIX     = 2'd0,
    CFG_SYMS_LOW  = 2'd1,
    CFG_SYMS_HIGH = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_DIV  = 3'b010,
    FS_PUSH = 3'b100
  } front_state_e;

  typedef struct packed {
    logic [4:0]   radix;
    logic [127:0] symbols;
  } srts_cfg_t;

  // One converted number: digits held least significant first
  typedef struct packed {
    logic                       negative;
    logic [5:0]                 ndig;
    logic [MaxDigits-1:0][3:0]  digits;
  } srts_entry_t;

  function automatic logic [7:0] sym_at(srts_cfg_t cfg, logic [3:0] k);
    return cfg.symbols[k*8 +: 8];
  endfunction

endpackage

`default_nettype wire

@@ rtl/srts_front.sv @@
// Front end: input item buffer, table check and digit extraction by a
// shared byte-per-cycle divider. Depends on srts_pkg.
`default_nettype none

module srts_front import srts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srts_cfg_t          cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] in_number_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output srts_entry_t        push_entry_o
);

  function automatic logic table_ok(srts_cfg_t cfg);
    logic       ok;
    logic [7:0] c;
    ok = (cfg.radix >= 5'd2) && (cfg.radix <= 5'(MaxRadix));
    for (int i = 0; i < SymSlots; i++) begin
      c = sym_at(cfg, 4'(i));
      if (5'(i) < cfg.radix) begin
        if (c == PlusSym || c == MinusSym) ok = 1'b0;
        for (int j = i + 1; j < SymSlots; j++) begin
          if (5'(j) < cfg.radix && sym_at(cfg, 4'(j)) == c) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  front_state_e       state_q, state_d;
  logic               buf_valid_q, buf_valid_d;
  logic signed [31:0] buf_num_q;
  logic [31:0]        mag_q;
  logic [31:0]        quo_q;
  logic [3:0]         rem_q;
  logic [1:0]         cnt_q;
  srts_entry_t        entry_q;

  logic        take;
  logic        cfg_ok;
  logic [7:0]  qbyte;
  logic [3:0]  rem_n;
  logic [31:0] quo_full;
  logic        pass_end;
  logic        conv_done;

  assign cfg_ok      = table_ok(cfg_i);
  assign in_ready_o  = !buf_valid_q;
  assign take        = (state_q == FS_IDLE) && buf_valid_q;
  assign buf_valid_d = (buf_valid_q && !take) || (in_valid_i && in_ready_o);

  // eight restoring steps: one dividend byte per cycle, remainder below radix
  always_comb begin
    logic [4:0] t;
    logic [3:0] r;
    r = rem_q;
    qbyte = '0;
    for (int b = 7; b >= 0; b--) begin
      t = {r, mag_q[24+b]};
      if (t >= cfg_i.radix) begin
        t = t - cfg_i.radix;
        qbyte[b] = 1'b1;
      end
      r = t[3:0];
    end
    rem_n = r;
  end

  assign quo_full  = {quo_q[23:0], qbyte};
  assign pass_end  = (cnt_q == 2'd3);
  assign conv_done = pass_end &&
                     ((quo_full == '0) || (entry_q.ndig == 6'(MaxDigits - 1)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: if (take && cfg_ok) state_d = FS_DIV;
      FS_DIV:  if (conv_done) state_d = FS_PUSH;
      FS_PUSH: if (push_ready_i) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      buf_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      buf_valid_q <= buf_valid_d;
      if (take) cnt_q <= '0;
      else if (state_q == FS_DIV) cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) buf_num_q <= in_number_i;
    if (take) begin
      mag_q            <= buf_num_q[31] ? 32'(-buf_num_q) : 32'(buf_num_q);
      rem_q            <= '0;
      entry_q.negative <= buf_num_q[31];
      entry_q.ndig     <= '0;
    end else if (state_q == FS_DIV) begin
      quo_q <= quo_full;
      if (pass_end) begin
        entry_q.digits[entry_q.ndig[4:0]] <= rem_n;
        entry_q.ndig                      <= entry_q.ndig + 6'd1;
        mag_q                             <= quo_full;
        rem_q                             <= '0;
      end else begin
        mag_q <= {mag_q[23:0], 8'd0};
        rem_q <= rem_n;
      end
    end
  end

  assign push_valid_o = (state_q == FS_PUSH);
  assign push_entry_o = entry_q;

endmodule

`default_nettype wire

@@ rtl/srts_queue.sv @@
// Short queue of converted numbers between front and back end.
// Depends on srts_pkg.
`default_nettype none

module srts_queue import srts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  srts_entry_t push_entry_i,
  output logic        head_valid_o,
  input  logic        pop_i,
  output srts_entry_t head_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  srts_entry_t       mem_q [QDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_q];

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= next_ptr(wr_q);
      if (pop)  rd_q <= next_ptr(rd_q);
      if (push && !pop) cnt_q <= cnt_q + CntW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_entry_i;
  end

endmodule

`default_nettype wire

@@ rtl/srts_back.sv @@
// Back end: walks the head entry most significant digit first, maps digits
// through the symbol table and drives the output register. Depends on srts_pkg.
`default_nettype none

module srts_back import srts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  srts_cfg_t   cfg_i,
  input  logic        head_valid_i,
  input  srts_entry_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_symbol_o,
  output logic        out_last_o
);

  logic       out_valid_q;
  logic [7:0] sym_q;
  logic       last_q;
  logic       sign_done_q;
  logic [4:0] cnt_q;

  logic       adv;
  logic       send_sign;
  logic [5:0] idx;
  logic       is_last;
  logic [7:0] dsym;

  assign adv       = head_valid_i && (!out_valid_q || out_ready_i);
  assign send_sign = head_i.negative && !sign_done_q;
  assign idx       = head_i.ndig - 6'd1 - 6'(cnt_q);
  assign dsym      = sym_at(cfg_i, head_i.digits[idx[4:0]]);
  assign is_last   = !send_sign && (idx == '0);
  assign pop_o     = adv && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sign_done_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (adv) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (adv) begin
        if (send_sign) begin
          sign_done_q <= 1'b1;
        end else if (is_last) begin
          sign_done_q <= 1'b0;
          cnt_q       <= '0;
        end else begin
          cnt_q <= cnt_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sym_q  <= send_sign ? MinusSym : dsym;
      last_q <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = sym_q;
  assign out_last_o   = last_q;

endmodule

`default_nettype wire

@@ rtl/signed_radix_to_symbols_top.sv @@
// Top level of the signed radix to symbols converter: configuration
// registers and the front end, queue and back end. Depends on srts_pkg.
//
// Converts each signed 32-bit item to text in the configured radix (2..16),
// one symbol byte per output item, most significant digit first, led by '-'
// for negative values; tlast marks the final symbol. If the radix is out of
// range, or the symbols in use repeat or contain '+' or '-', the item is
// consumed and nothing is emitted. The divider takes one dividend byte per
// cycle and the whole dividend once per digit, so it sets the sustained rate.
// The output side sends one symbol per cycle while tready is high and an entry
// is queued; a two-entry queue and an input buffer let both ends stall
// independently. Configuration must be written only while no item is in
// flight; the block itself does not enforce this.
`default_nettype none

module signed_radix_to_symbols_top import srts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic signed [31:0] s_axis_tdata_i,   // [31:0] number
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o,   // [7:0] symbol
  output logic               m_axis_tlast_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  srts_cfg_t   cfg_q;
  logic        push_valid, push_ready;
  srts_entry_t push_entry;
  logic        head_valid, pop;
  srts_entry_t head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RADIX:     cfg_q.radix           <= cfg_data_i[4:0];
        CFG_SYMS_LOW:  cfg_q.symbols[63:0]   <= cfg_data_i;
        CFG_SYMS_HIGH: cfg_q.symbols[127:64] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  srts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_number_i  (s_axis_tdata_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  srts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_o       (head)
  );

  srts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_symbol_o (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

@@ rtl/srts_checker.sv @@
// Port-level checks for signed_radix_to_symbols_top, bound to the top level.
// Depends on srts_pkg.
`default_nettype none

module srts_checker import srts_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("output item changed while stalled");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tdata_o == MinusSym) |->
      !m_axis_tlast_o)
    else $error("minus symbol closed a run");

  a_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input buffer took a second item");

  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid straight after reset");

endmodule

bind signed_radix_to_symbols_top srts_checker u_chk (.*);

`default_nettype wire

@@ tb/sv/tb_signed_radix_to_symbols_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for signed_radix_to_symbols_top: numbers in, symbol text out.
// Predicts each symbol from its own copy of the radix and symbol table.
// Depends on srts_pkg and the top level only.

module tb_signed_radix_to_symbols_top;
  import srts_pkg::*;

  localparam int          CycleLimit = 1_000_000;
  localparam int          SettleCyc  = 200;
  localparam int          IdlePct    = 31;
  localparam logic [1:0]  CfgNoReg   = 2'd3;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } sym_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic signed [31:0] s_axis_tdata_i = '0;   // [31:0] number
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [7:0]         m_axis_tdata_o;        // [7:0] symbol
  logic               m_axis_tlast_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;

  logic [4:0]   radix_reg = '0;
  logic [127:0] syms_reg = '0;
  sym_item_t    pending_syms[$];
  bit           quiet = 1'b0;
  int           errors, numbers_sent, productive, symbols_checked, tables_loaded, cycles;

  signed_radix_to_symbols_top dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready_i <= quiet ? 1'b1 : ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d symbols outstanding", cycles, pending_syms.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    sym_item_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_syms.size() == 0) begin
        $error("unexpected item: symbol %h last %b", m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = pending_syms.pop_front();
        symbols_checked++;
        if (m_axis_tdata_o !== want.symbol) begin
          $error("symbol: expected %h, actual %h", want.symbol, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %b, actual %b", want.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [7:0] digit_sym(int k);
    return syms_reg[k*8 +: 8];
  endfunction

  function automatic bit table_usable();
    if (radix_reg < 2 || radix_reg > MaxRadix) return 1'b0;
    for (int i = 0; i < radix_reg; i++) begin
      if (digit_sym(i) == PlusSym || digit_sym(i) == MinusSym) return 1'b0;
      for (int j = i + 1; j < radix_reg; j++)
        if (digit_sym(j) == digit_sym(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_text(input logic signed [31:0] num);
    logic [31:0] mag;
    logic [7:0]  digits[$];
    if (!table_usable()) return;
    mag = num[31] ? (32'd0 - num) : num;
    do begin
      digits.push_front(digit_sym(int'(mag % radix_reg)));
      mag = mag / radix_reg;
    end while (mag != 0);
    if (num[31]) pending_syms.push_back('{symbol: MinusSym, last: 1'b0});
    foreach (digits[k])
      pending_syms.push_back('{symbol: digits[k], last: (k == digits.size() - 1)});
    productive++;
  endfunction

  // tvalid stays high across back-to-back items; an idle gap or a drain lowers it
  task automatic send_number(input logic signed [31:0] num);
    if (!quiet)
      while ($urandom_range(99) < IdlePct) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= num;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_text(num);
    numbers_sent++;
  endtask

  task automatic drain(input int settle);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_syms.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data, input bit more);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RADIX:     radix_reg = data[4:0];
      CFG_SYMS_LOW:  syms_reg[63:0] = data;
      CFG_SYMS_HIGH: syms_reg[127:64] = data;
      default: ;
    endcase
    if (!more) cfg_valid_i <= 1'b0;
  endtask

  // upper radix bits are junk on purpose: only the low five count
  task automatic set_table(input logic [4:0] r, input logic [127:0] syms);
    logic [63:0] word;
    drain(SettleCyc);
    word = {$urandom, $urandom};
    word[4:0] = r;
    write_reg(CFG_RADIX, word, 1'b1);
    write_reg(CFG_SYMS_LOW, syms[63:0], 1'b1);
    write_reg(CFG_SYMS_HIGH, syms[127:64], 1'b0);
    tables_loaded++;
  endtask

  function automatic void random_table(output logic [4:0] r, output logic [127:0] syms);
    logic [7:0] b;
    bit         clash;
    int         i, j;
    r = 5'($urandom_range(16, 2));
    syms = {$urandom, $urandom, $urandom, $urandom};
    for (int k = 0; k < r; k++) begin
      do begin
        b = 8'($urandom);
        clash = (b == PlusSym) || (b == MinusSym);
        for (int n = 0; n < k; n++) if (syms[n*8 +: 8] == b) clash = 1'b1;
      end while (clash);
      syms[k*8 +: 8] = b;
    end
    case ($urandom_range(11))
      0: r = 5'($urandom_range(1));
      1: r = 5'($urandom_range(31, 17));
      2: begin
        j = $urandom_range(r - 1, 1);
        i = $urandom_range(j - 1);
        syms[j*8 +: 8] = syms[i*8 +: 8];
      end
      3: begin
        i = $urandom_range(r - 1);
        syms[i*8 +: 8] = $urandom_range(1) ? PlusSym : MinusSym;
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [31:0] random_number();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(40) - 20;
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  localparam logic [127:0] DecTable  = {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130};
  localparam logic [127:0] HexTable  = {64'h6665_6463_6261_3938, 64'h3736_3534_3332_3130};

  task automatic test_reset_state();
    send_number(32'sd123);
  endtask

  task automatic test_decimal();
    set_table(5'd10, DecTable);
    send_number(32'sd0);
    send_number(32'sd1);
    send_number(-32'sd1);
    send_number(32'sd9);
    send_number(32'sd10);
    send_number(32'sh7FFF_FFFF);
    send_number(32'sh8000_0000);
  endtask

  task automatic test_binary_hex();
    set_table(5'd2, DecTable);
    send_number(32'sh8000_0000);
    send_number(32'sh7FFF_FFFF);
    set_table(5'd16, HexTable);
    send_number(32'shDEAD_BEEF);
    send_number(32'sh7FFF_FFFF);
  endtask

  task automatic test_symbol_rules();
    // zero byte as digit 0; unused slots 3 to 7 hold minus signs, the rest 0xFF
    set_table(5'd3, {64'hFFFF_FFFF_FFFF_FFFF, 64'h2D2D_2D2D_2D62_6100});
    send_number(-32'sd5);
    send_number(32'sd0);
    set_table(5'd1, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
    send_number(32'sd7);
    set_table(5'd17, HexTable);
    send_number(32'sd7);
    set_table(5'd31, HexTable);
    send_number(32'sd7);
    set_table(5'd10, {64'h0000_0000_0000_3038, DecTable[63:0]});
    send_number(32'sd7);
    set_table(5'd16, {64'h2B65_6463_6261_3938, HexTable[63:0]});
    send_number(32'sd7);
    set_table(5'd16, {HexTable[127:64], 64'h3736_3534_3332_312D});
    send_number(32'sd7);
  endtask

  task automatic test_stray_index();
    set_table(5'd10, DecTable);
    write_reg(CfgNoReg, 64'h0, 1'b0);
    send_number(32'sd42);
    send_number(-32'sd300);
  endtask

  task automatic test_random_tables();
    logic [4:0]   r;
    logic [127:0] syms;
    int           phase;
    int           burst;
    phase = 0;
    while (numbers_sent < 110) begin
      random_table(r, syms);
      set_table(r, syms);
      quiet = (phase == 2);
      burst = table_usable() ? 12 : 4;
      for (int n = 0; n < burst; n++) begin
        send_number(random_number());
        if (n == 5 && phase % 3 == 1) drain(0);
      end
      quiet = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_decimal();
    test_binary_hex();
    test_symbol_rules();
    test_stray_index();
    test_random_tables();
    drain(SettleCyc);
    $display("%0d numbers sent (%0d turned into text) over %0d symbol tables",
             numbers_sent, productive, tables_loaded);
    $display("(radix 0 to 31, bad tables included); %0d symbols compared, %0d mismatches",
             symbols_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/srts_pkg.sv
rtl/srts_front.sv
rtl/srts_queue.sv
rtl/srts_back.sv
rtl/signed_radix_to_symbols_top.sv
rtl/srts_checker.sv
tb/sv/tb_signed_radix_to_symbols_top.sv
